// ----- rtl/bgd_pkg.sv -----
package bgd_pkg;

  localparam int CFG_W   = 8;
  localparam int CFG_IDX_W = 3;
  localparam int EV_W    = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MAX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_WAIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_LONG = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SWAP        = 3'd4;

  localparam logic [CFG_W-1:0] LONG_PRESS_RST  = 8'd30;
  localparam logic [CFG_W-1:0] SHORT_MAX_RST   = 8'd4;
  localparam logic [CFG_W-1:0] SECOND_WAIT_RST = 8'd6;
  localparam logic [CFG_W-1:0] SECOND_LONG_RST = 8'd20;

  localparam int EV_PWR_CLICK      = 0;
  localparam int EV_PWR_LONG       = 1;
  localparam int EV_PWR_CLICK_LONG = 2;
  localparam int EV_UP_CLICK       = 3;
  localparam int EV_UP_LONG        = 4;
  localparam int EV_DN_CLICK       = 5;
  localparam int EV_DN_LONG        = 6;
  localparam int EV_M_CLICK        = 7;
  localparam int EV_M_LONG         = 8;
  localparam int EV_UPDN_LONG      = 9;
  localparam int EV_PWRUP_LONG     = 10;
  localparam int EV_PWRDN_LONG     = 11;
  localparam int EV_ALL3_LONG      = 12;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_PRESS = 2'd1;
  localparam logic [1:0] PH_HELD  = 2'd2;

  typedef struct packed {
    logic            up_pin;
    logic            down_pin;
    logic            power_pin;
    logic            mode_pin;
    logic [EV_W-1:0] clear_mask;
    logic            clear_all;
  } tick_t;

  typedef struct packed {
    logic [EV_W-1:0] pending_events;
    logic [EV_W-1:0] new_events;
    logic            locked_out;
  } report_t;

  typedef struct packed {
    logic click;
    logic long_hit;
    logic pwr_combo;
    logic pair_long;
    logic all3;
  } press_hit_t;

endpackage

// ----- rtl/bgd_press.sv -----
module bgd_press #(
  parameter int COUNT_BITS = 8
) (
  input  logic [1:0]               phase,
  input  logic [COUNT_BITS-1:0]    count,
  input  logic                     me,
  input  logic                     other,
  input  logic                     pwr,
  input  logic [bgd_pkg::CFG_W-1:0] long_ticks,
  output logic [1:0]               phase_next,
  output logic [COUNT_BITS-1:0]    count_next,
  output bgd_pkg::press_hit_t      hit
);

  localparam int CMP_W = (COUNT_BITS > bgd_pkg::CFG_W) ? COUNT_BITS : bgd_pkg::CFG_W;

  logic [COUNT_BITS-1:0] count_inc;
  logic                  over;

  assign count_inc = (count == '1) ? count : count + COUNT_BITS'(1);
  assign over      = CMP_W'(count) > CMP_W'(long_ticks);

  always_comb begin
    phase_next = phase;
    count_next = count;
    hit        = '0;
    unique case (phase)
      bgd_pkg::PH_IDLE: begin
        if (me) begin
          count_next = '0;
          phase_next = bgd_pkg::PH_PRESS;
        end
      end
      bgd_pkg::PH_PRESS: begin
        count_next = count_inc;
        if (over) begin
          if (pwr && other) begin
            hit.all3 = 1'b1;
          end else if (pwr) begin
            hit.pwr_combo = 1'b1;
          end else if (other) begin
            hit.pair_long = 1'b1;
          end else begin
            hit.long_hit = 1'b1;
          end
          phase_next = bgd_pkg::PH_HELD;
          count_next = '0;
        end else if (!me) begin
          hit.click  = 1'b1;
          phase_next = bgd_pkg::PH_IDLE;
        end
      end
      bgd_pkg::PH_HELD: begin
        if (!me) phase_next = bgd_pkg::PH_IDLE;
      end
      default: begin
        phase_next = bgd_pkg::PH_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/button_gesture_detector.sv -----
// Channel  Direction  Handshake                Payload
// tick     in         tick_valid / tick_stall  bgd_pkg::tick_t
// report   out        report_valid / report_stall  bgd_pkg::report_t
// cfg      in         cfg_write                cfg_index, cfg_data
//
// One tick per cycle while no report stalls: a tick waits in the input register
// until it advances, and then its report lands in the output register at the
// same edge that updates all machines.
// Reset (rst, synchronous) clears machines, events and lockout, and loads
// the default thresholds.
// A stalled report holds the tick behind it; tick_stall rises only then.
module button_gesture_detector #(
  parameter int COUNT_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [bgd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bgd_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          tick_valid,
  output logic                          tick_stall,
  input  bgd_pkg::tick_t                tick,
  output logic                          report_valid,
  input  logic                          report_stall,
  output bgd_pkg::report_t              report
);

  localparam int CMP_W = (COUNT_BITS > bgd_pkg::CFG_W) ? COUNT_BITS : bgd_pkg::CFG_W;

  typedef enum logic [2:0] {
    PWR_IDLE,
    PWR_PRESS,
    PWR_HELD,
    PWR_GAP,
    PWR_SECOND
  } pwr_phase_t;

  logic [bgd_pkg::CFG_W-1:0] long_press_ticks;
  logic [bgd_pkg::CFG_W-1:0] short_press_max_ticks;
  logic [bgd_pkg::CFG_W-1:0] second_press_wait_ticks;
  logic [bgd_pkg::CFG_W-1:0] second_long_ticks;
  logic                      swap_up_down;

  logic           tick_q_valid;
  bgd_pkg::tick_t tick_q;
  logic           advance;

  pwr_phase_t            power_phase, power_phase_next;
  logic [COUNT_BITS-1:0] power_count, power_count_next;
  logic [1:0]            up_phase, up_phase_next;
  logic [COUNT_BITS-1:0] up_count, up_count_next;
  logic [1:0]            down_phase, down_phase_next;
  logic [COUNT_BITS-1:0] down_count, down_count_next;
  logic [1:0]            mode_phase, mode_phase_next;
  logic [COUNT_BITS-1:0] mode_count, mode_count_next;
  logic [bgd_pkg::EV_W-1:0] event_flags, event_flags_next;
  logic                  release_lockout, release_lockout_next;
  bgd_pkg::report_t      report_next;

  logic up, dn, pwr, m;
  logic lock_c, locked;
  logic [bgd_pkg::EV_W-1:0] flags_c;
  pwr_phase_t pwr_ph_c;
  logic [1:0] up_ph_c, dn_ph_c, m_ph_c;
  logic [1:0] dn_ph_in, m_ph_in;

  pwr_phase_t            pwr_ph_run;
  logic [COUNT_BITS-1:0] pwr_cnt_run, pwr_inc;
  logic [bgd_pkg::EV_W-1:0] pwr_ev, up_ev, dn_ev, m_ev, raised;

  logic [1:0]            up_ph_run, dn_ph_run, m_ph_run;
  logic [COUNT_BITS-1:0] up_cnt_run, dn_cnt_run, m_cnt_run;
  bgd_pkg::press_hit_t   up_hit, dn_hit, m_hit;

  assign advance    = tick_q_valid && (!report_valid || !report_stall);
  assign tick_stall = tick_q_valid && !advance;

  assign up  = swap_up_down ? !tick_q.down_pin : !tick_q.up_pin;
  assign dn  = swap_up_down ? !tick_q.up_pin : !tick_q.down_pin;
  assign pwr = !tick_q.power_pin;
  assign m   = !tick_q.mode_pin;

  assign lock_c   = tick_q.clear_all || release_lockout;
  assign flags_c  = tick_q.clear_all ? '0 : (event_flags & ~tick_q.clear_mask);
  assign pwr_ph_c = tick_q.clear_all ? PWR_IDLE : power_phase;
  assign up_ph_c  = tick_q.clear_all ? bgd_pkg::PH_IDLE : up_phase;
  assign dn_ph_c  = tick_q.clear_all ? bgd_pkg::PH_IDLE : down_phase;
  assign m_ph_c   = tick_q.clear_all ? bgd_pkg::PH_IDLE : mode_phase;
  assign locked   = lock_c && (up || dn || pwr || m);

  assign pwr_inc = (power_count == '1) ? power_count : power_count + COUNT_BITS'(1);

  always_comb begin
    pwr_ph_run  = pwr_ph_c;
    pwr_cnt_run = power_count;
    pwr_ev      = '0;
    unique case (pwr_ph_c)
      PWR_IDLE: begin
        if (pwr) begin
          pwr_cnt_run = '0;
          pwr_ph_run  = PWR_PRESS;
        end
      end
      PWR_PRESS: begin
        pwr_cnt_run = pwr_inc;
        if (CMP_W'(pwr_inc) > CMP_W'(long_press_ticks)) begin
          pwr_ev[bgd_pkg::EV_PWR_LONG] = 1'b1;
          pwr_ph_run = PWR_HELD;
        end else if (!pwr) begin
          if (CMP_W'(pwr_inc) <= CMP_W'(short_press_max_ticks)) begin
            pwr_cnt_run = '0;
            pwr_ph_run  = PWR_GAP;
          end else begin
            pwr_ev[bgd_pkg::EV_PWR_CLICK] = 1'b1;
            pwr_ph_run = PWR_IDLE;
          end
        end
      end
      PWR_HELD: begin
        if (!pwr) pwr_ph_run = PWR_IDLE;
      end
      PWR_GAP: begin
        pwr_cnt_run = pwr_inc;
        if (pwr) begin
          pwr_cnt_run = '0;
          pwr_ph_run  = PWR_SECOND;
        end else if (CMP_W'(pwr_inc) > CMP_W'(second_press_wait_ticks)) begin
          pwr_ev[bgd_pkg::EV_PWR_CLICK] = 1'b1;
          pwr_ph_run = PWR_IDLE;
        end
      end
      PWR_SECOND: begin
        pwr_cnt_run = pwr_inc;
        if (CMP_W'(pwr_inc) > CMP_W'(second_long_ticks)) begin
          pwr_ev[bgd_pkg::EV_PWR_CLICK_LONG] = 1'b1;
          pwr_ph_run = PWR_HELD;
        end else if (!pwr) begin
          pwr_ev[bgd_pkg::EV_PWR_CLICK] = 1'b1;
          pwr_ph_run = PWR_IDLE;
        end
      end
      default: begin
        pwr_ph_run = PWR_IDLE;
      end
    endcase
  end

  bgd_press #(.COUNT_BITS(COUNT_BITS)) u_up (
    .phase      (up_ph_c),
    .count      (up_count),
    .me         (up),
    .other      (dn),
    .pwr        (pwr),
    .long_ticks (long_press_ticks),
    .phase_next (up_ph_run),
    .count_next (up_cnt_run),
    .hit        (up_hit)
  );

  assign dn_ph_in = up_hit.all3 ? bgd_pkg::PH_IDLE : dn_ph_c;

  bgd_press #(.COUNT_BITS(COUNT_BITS)) u_down (
    .phase      (dn_ph_in),
    .count      (down_count),
    .me         (dn),
    .other      (up),
    .pwr        (pwr),
    .long_ticks (long_press_ticks),
    .phase_next (dn_ph_run),
    .count_next (dn_cnt_run),
    .hit        (dn_hit)
  );

  assign m_ph_in = (up_hit.all3 || dn_hit.all3) ? bgd_pkg::PH_IDLE : m_ph_c;

  bgd_press #(.COUNT_BITS(COUNT_BITS)) u_mode (
    .phase      (m_ph_in),
    .count      (mode_count),
    .me         (m),
    .other      (1'b0),
    .pwr        (1'b0),
    .long_ticks (long_press_ticks),
    .phase_next (m_ph_run),
    .count_next (m_cnt_run),
    .hit        (m_hit)
  );

  always_comb begin
    up_ev = '0;
    up_ev[bgd_pkg::EV_UP_CLICK]   = up_hit.click;
    up_ev[bgd_pkg::EV_UP_LONG]    = up_hit.long_hit;
    up_ev[bgd_pkg::EV_PWRUP_LONG] = up_hit.pwr_combo;
    up_ev[bgd_pkg::EV_UPDN_LONG]  = up_hit.pair_long;
    dn_ev = '0;
    dn_ev[bgd_pkg::EV_DN_CLICK]   = dn_hit.click;
    dn_ev[bgd_pkg::EV_DN_LONG]    = dn_hit.long_hit;
    dn_ev[bgd_pkg::EV_PWRDN_LONG] = dn_hit.pwr_combo;
    dn_ev[bgd_pkg::EV_UPDN_LONG]  = dn_hit.pair_long;
    m_ev = '0;
    m_ev[bgd_pkg::EV_M_CLICK] = m_hit.click;
    m_ev[bgd_pkg::EV_M_LONG]  = m_hit.long_hit;
  end

  always_comb begin
    power_phase_next     = pwr_ph_c;
    power_count_next     = power_count;
    up_phase_next        = up_ph_c;
    up_count_next        = up_count;
    down_phase_next      = dn_ph_c;
    down_count_next      = down_count;
    mode_phase_next      = m_ph_c;
    mode_count_next      = mode_count;
    event_flags_next     = flags_c;
    release_lockout_next = lock_c;
    raised               = '0;
    report_next.locked_out = locked;
    if (!locked) begin
      release_lockout_next = 1'b0;
      power_phase_next = pwr_ph_run;
      power_count_next = pwr_cnt_run;
      up_phase_next    = up_ph_run;
      up_count_next    = up_cnt_run;
      down_phase_next  = dn_ph_run;
      down_count_next  = dn_cnt_run;
      mode_phase_next  = m_ph_run;
      mode_count_next  = m_cnt_run;
      raised           = pwr_ev;
      event_flags_next = flags_c | pwr_ev;

      if (up_hit.all3) begin
        raised = '0;
        event_flags_next = '0;
        power_phase_next = PWR_IDLE;
        release_lockout_next = 1'b1;
      end
      raised = raised | up_ev;
      event_flags_next = event_flags_next | up_ev;
      raised[bgd_pkg::EV_ALL3_LONG] = raised[bgd_pkg::EV_ALL3_LONG] | up_hit.all3;
      event_flags_next[bgd_pkg::EV_ALL3_LONG] =
        event_flags_next[bgd_pkg::EV_ALL3_LONG] | up_hit.all3;

      if (dn_hit.all3) begin
        raised = '0;
        event_flags_next = '0;
        power_phase_next = PWR_IDLE;
        up_phase_next    = bgd_pkg::PH_IDLE;
        release_lockout_next = 1'b1;
      end
      raised = raised | dn_ev;
      event_flags_next = event_flags_next | dn_ev;
      raised[bgd_pkg::EV_ALL3_LONG] = raised[bgd_pkg::EV_ALL3_LONG] | dn_hit.all3;
      event_flags_next[bgd_pkg::EV_ALL3_LONG] =
        event_flags_next[bgd_pkg::EV_ALL3_LONG] | dn_hit.all3;

      raised = raised | m_ev;
      event_flags_next = event_flags_next | m_ev;
    end
    report_next.pending_events = event_flags_next;
    report_next.new_events     = raised;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks        <= bgd_pkg::LONG_PRESS_RST;
      short_press_max_ticks   <= bgd_pkg::SHORT_MAX_RST;
      second_press_wait_ticks <= bgd_pkg::SECOND_WAIT_RST;
      second_long_ticks       <= bgd_pkg::SECOND_LONG_RST;
      swap_up_down            <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bgd_pkg::CFG_LONG_PRESS:  long_press_ticks        <= cfg_data;
        bgd_pkg::CFG_SHORT_MAX:   short_press_max_ticks   <= cfg_data;
        bgd_pkg::CFG_SECOND_WAIT: second_press_wait_ticks <= cfg_data;
        bgd_pkg::CFG_SECOND_LONG: second_long_ticks       <= cfg_data;
        bgd_pkg::CFG_SWAP:        swap_up_down            <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_q_valid <= 1'b0;
    end else if (tick_valid && !tick_stall) begin
      tick_q_valid <= 1'b1;
    end else if (advance) begin
      tick_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_valid && !tick_stall) tick_q <= tick;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      power_phase     <= PWR_IDLE;
      power_count     <= '0;
      up_phase        <= bgd_pkg::PH_IDLE;
      up_count        <= '0;
      down_phase      <= bgd_pkg::PH_IDLE;
      down_count      <= '0;
      mode_phase      <= bgd_pkg::PH_IDLE;
      mode_count      <= '0;
      event_flags     <= '0;
      release_lockout <= 1'b0;
      report_valid    <= 1'b0;
    end else if (advance) begin
      power_phase     <= power_phase_next;
      power_count     <= power_count_next;
      up_phase        <= up_phase_next;
      up_count        <= up_count_next;
      down_phase      <= down_phase_next;
      down_count      <= down_count_next;
      mode_phase      <= mode_phase_next;
      mode_count      <= mode_count_next;
      event_flags     <= event_flags_next;
      release_lockout <= release_lockout_next;
      report_valid    <= 1'b1;
    end else if (report_valid && !report_stall) begin
      report_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) report <= report_next;
  end

endmodule
